/* hw/rtl/bcc_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package bcc_pkg;

	// Width of the indices n and k, and of the divisor and the falling factor.
	localparam int unsigned INDEX_WIDTH = 32;
	// Width of the coefficient field on the result channel.
	localparam int unsigned COEF_WIDTH  = 64;

	typedef struct packed {
		logic [INDEX_WIDTH-1:0] n_value;
		logic [INDEX_WIDTH-1:0] k_value;
	} arg_item_t;

	typedef struct packed {
		logic [COEF_WIDTH-1:0] coefficient;
		logic                  overflow;
	} res_item_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic capture;
		logic setup;
		logic mul_lo;
		logic mul_hi;
		logic div_load;
		logic div_step;
		logic step;
		logic load_out;
	} bcc_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic loop_done;
		logic too_wide;
		logic div_last;
	} bcc_status_t;

endpackage

`default_nettype wire

/* hw/rtl/bcc_datapath.sv */
`timescale 1ns / 1ps
`default_nettype none

module bcc_datapath #(
	parameter int unsigned RESULT_WIDTH = 64
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire bcc_pkg::bcc_cmd_t   cmd,
	output bcc_pkg::bcc_status_t     status,
	input  wire bcc_pkg::arg_item_t  arg,
	output bcc_pkg::res_item_t       res
);

	localparam int unsigned IW      = bcc_pkg::INDEX_WIDTH;
	localparam int unsigned PW      = RESULT_WIDTH + IW;
	localparam int unsigned CW      = $clog2(RESULT_WIDTH);
	localparam logic [CW-1:0] LAST  = CW'(RESULT_WIDTH - 1);

	logic [IW-1:0]           n_q;
	logic [IW-1:0]           k_q;
	logic [IW-1:0]           i_q;
	logic [IW-1:0]           m_q;
	logic [RESULT_WIDTH-1:0] acc_q;
	logic                    ovf_q;
	logic [2*IW-1:0]         prod_q;
	logic [2*IW-1:0]         plo_q;
	logic [IW-1:0]           rem_q;
	logic [RESULT_WIDTH-1:0] quo_q;
	logic [CW-1:0]           cnt_q;
	bcc_pkg::res_item_t      res_q;

	logic [63:0]      acc64;
	logic [IW-1:0]    mult_a;
	logic [2*IW-1:0]  prod_c;
	logic [3*IW-1:0]  wide_c;
	logic [PW-1:0]    full_c;
	logic [IW-1:0]    top_c;
	logic [IW:0]      trial_c;
	logic [IW:0]      diff_c;
	logic             fits_c;
	logic [IW-1:0]    nk_diff;

	// The accumulator is taken as two 32-bit halves through one multiplier.
	assign acc64   = 64'(acc_q);
	assign mult_a  = cmd.mul_hi ? acc64[63:32] : acc64[31:0];
	assign prod_c  = {{IW{1'b0}}, mult_a} * {{IW{1'b0}}, m_q};

	// acc * m assembled from the two partial products.
	assign wide_c  = {prod_q, {IW{1'b0}}} + {{IW{1'b0}}, plo_q};
	assign full_c  = wide_c[PW-1:0];
	assign top_c   = full_c[PW-1:RESULT_WIDTH];

	// One restoring division step.
	assign trial_c = {rem_q, quo_q[RESULT_WIDTH-1]};
	assign diff_c  = trial_c - {1'b0, i_q};
	assign fits_c  = trial_c >= {1'b0, i_q};

	assign nk_diff = n_q - k_q;

	assign status.loop_done = i_q > k_q;
	assign status.too_wide  = top_c >= i_q;
	assign status.div_last  = cnt_q == LAST;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			n_q <= arg.n_value;
			k_q <= arg.k_value;
		end
		if (cmd.setup) begin
			i_q   <= IW'(1);
			m_q   <= n_q;
			ovf_q <= 1'b0;
			if (k_q > n_q) begin
				// No way to choose more than n: the loop is skipped, result zero.
				k_q   <= '0;
				acc_q <= '0;
			end else begin
				k_q   <= (nk_diff < k_q) ? nk_diff : k_q;
				acc_q <= RESULT_WIDTH'(1);
			end
		end
		if (cmd.mul_lo) begin
			prod_q <= prod_c;
		end
		if (cmd.mul_hi) begin
			plo_q  <= prod_q;
			prod_q <= prod_c;
		end
		if (cmd.div_load) begin
			rem_q <= top_c;
			quo_q <= full_c[RESULT_WIDTH-1:0];
			cnt_q <= '0;
			if (status.too_wide) begin
				ovf_q <= 1'b1;
			end
		end
		if (cmd.div_step) begin
			cnt_q <= cnt_q + CW'(1);
			if (fits_c) begin
				rem_q <= diff_c[IW-1:0];
				quo_q <= {quo_q[RESULT_WIDTH-2:0], 1'b1};
			end else begin
				rem_q <= trial_c[IW-1:0];
				quo_q <= {quo_q[RESULT_WIDTH-2:0], 1'b0};
			end
		end
		if (cmd.step) begin
			acc_q <= quo_q;
			i_q   <= i_q + IW'(1);
			m_q   <= m_q - IW'(1);
		end
		if (cmd.load_out) begin
			res_q.coefficient <= ovf_q ? '0 : bcc_pkg::COEF_WIDTH'(acc_q);
			res_q.overflow    <= ovf_q;
		end
	end

	assign res = res_q;

	// The partial remainder stays below the divisor through the whole division.
	a_rem_below_div: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_step |-> (rem_q < i_q))
		else $error("division remainder reached the divisor");

endmodule

`default_nettype wire

/* hw/rtl/bcc_controller.sv */
`timescale 1ns / 1ps
`default_nettype none

module bcc_controller (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  arg_valid,
	output logic                       arg_stall,
	output logic                       res_valid,
	input  wire logic                  res_stall,
	input  wire bcc_pkg::bcc_status_t  status,
	output bcc_pkg::bcc_cmd_t          cmd
);

	localparam logic [3:0] ST_IDLE     = 4'd0;
	localparam logic [3:0] ST_SETUP    = 4'd1;
	localparam logic [3:0] ST_LOOP     = 4'd2;
	localparam logic [3:0] ST_MUL_LO   = 4'd3;
	localparam logic [3:0] ST_MUL_HI   = 4'd4;
	localparam logic [3:0] ST_DIV_LOAD = 4'd5;
	localparam logic [3:0] ST_DIV      = 4'd6;
	localparam logic [3:0] ST_STEP     = 4'd7;
	localparam logic [3:0] ST_FINISH   = 4'd8;

	logic [3:0] state_q;
	logic [3:0] state_d;
	logic       res_valid_q;
	logic       out_free;

	assign out_free  = !res_valid_q || !res_stall;
	assign arg_stall = state_q != ST_IDLE;
	assign res_valid = res_valid_q;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (arg_valid) begin
					cmd.capture = 1'b1;
					state_d     = ST_SETUP;
				end
			end
			ST_SETUP: begin
				cmd.setup = 1'b1;
				state_d   = ST_LOOP;
			end
			ST_LOOP: begin
				state_d = status.loop_done ? ST_FINISH : ST_MUL_LO;
			end
			ST_MUL_LO: begin
				cmd.mul_lo = 1'b1;
				state_d    = ST_MUL_HI;
			end
			ST_MUL_HI: begin
				cmd.mul_hi = 1'b1;
				state_d    = ST_DIV_LOAD;
			end
			ST_DIV_LOAD: begin
				cmd.div_load = 1'b1;
				state_d      = status.too_wide ? ST_FINISH : ST_DIV;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (status.div_last) begin
					state_d = ST_STEP;
				end
			end
			ST_STEP: begin
				cmd.step = 1'b1;
				state_d  = ST_LOOP;
			end
			ST_FINISH: begin
				if (out_free) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// An accepted item always goes on to the setup cycle.
	a_accept_setup: assert property (@(posedge clk) disable iff (!arst_n)
		(arg_valid && !arg_stall) |=> (state_q == ST_SETUP))
		else $error("accepted item did not enter setup");

	// A new result is never written over one that is still waiting.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> (!res_valid_q || !res_stall))
		else $error("result register overwritten while stalled");

	// The last division cycle always hands over to the accumulator update.
	a_div_to_step: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV && status.div_last) |=> (state_q == ST_STEP))
		else $error("division did not end in the update step");

endmodule

`default_nettype wire

/* hw/rtl/binomial_coefficient_checked.sv */
// Exact binomial coefficient C(n,k) of two 32-bit unsigned indices. Each item
// returns one result item: the exact coefficient when it fits in RESULT_WIDTH
// bits, or coefficient zero with the overflow flag set when it does not; k above
// n gives zero without overflow. The block works on one item at a time. With
// j = min(k, n-k) steps actually run (the walk stops at the first step that
// overflows, so j stays near 34 at the full 64-bit width), each step runs the
// bit-serial division once (96-by-32 at RESULT_WIDTH = 64), one quotient bit
// per cycle. A finished result waits in the output register while the next
// item is accepted.
`timescale 1ns / 1ps
`default_nettype none

module binomial_coefficient_checked #(
	parameter int unsigned RESULT_WIDTH = 64
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                arg_valid,
	output logic                     arg_stall,
	input  wire bcc_pkg::arg_item_t  arg,
	output logic                     res_valid,
	input  wire logic                res_stall,
	output bcc_pkg::res_item_t       res
);

	// Each step forms C(n,i) = C(n,i-1) * (n-i+1) / i. The product is built
	// from two 32-by-32 partial products, then divided serially by i. Since
	// the division is exact, the quotient is the next partial coefficient.
	// If the top 32 bits of the product are already at least i, the quotient
	// cannot fit, and because the partial values only grow while i stays at
	// or below n/2, the whole item is flagged as overflow at once.

	bcc_pkg::bcc_cmd_t    cmd;
	bcc_pkg::bcc_status_t status;

	bcc_controller u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.arg_valid (arg_valid),
		.arg_stall (arg_stall),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.status    (status),
		.cmd       (cmd)
	);

	bcc_datapath #(
		.RESULT_WIDTH (RESULT_WIDTH)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.status (status),
		.arg    (arg),
		.res    (res)
	);

endmodule

`default_nettype wire
